[design/distance_grid_point_query_defines.svh]
// Assertion macros for the distance grid point query block
`ifndef DISTANCE_GRID_POINT_QUERY_DEFINES_SVH
`define DISTANCE_GRID_POINT_QUERY_DEFINES_SVH

// same-cycle implication
`define DGPQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dgpq assertion failed");

// next-cycle implication
`define DGPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dgpq assertion failed");

`endif

[design/dgpq_pkg.sv]
// Types and constants shared by the distance grid point query block
`default_nettype none
package dgpq_pkg;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] CFG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_SPACING_X = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_SPACING_Y = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_SPACING_Z = 3'd5;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [30:0] SPACING_RST = 31'd65536;

	localparam int DIV_NW    = 34;
	localparam int DIV_DW    = 32;
	localparam int MUL_W     = 34;
	localparam int PROD_W    = 50;
	localparam int ACC_W     = 52;
	localparam int TOP_W     = 41;
	localparam int CORR_W    = 41;
	localparam int RND_SHIFT = 14;
	localparam int RND_BIAS  = 8192;
	localparam int ENTRY_W   = 80;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [3:0]         cell_x;
		logic [3:0]         cell_y;
		logic [3:0]         cell_z;
		logic signed [15:0] entry_dir_x;
		logic signed [15:0] entry_dir_y;
		logic signed [15:0] entry_dir_z;
		logic signed [31:0] entry_dist;
	} dgpq_req_t;

	typedef struct packed {
		logic               in_range;
		logic               inside_res;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [30:0]        distance;
	} dgpq_rsp_t;

	typedef struct packed {
		logic [CFG_AW-1:0] addr;
		logic [31:0]       wdata;
	} dgpq_cfg_t;

endpackage
`default_nettype wire

[design/dgpq_if.sv]
// Valid/ready channel interfaces for requests, results and configuration
`default_nettype none
interface dgpq_req_if import dgpq_pkg::*; ();
	logic      valid;
	logic      ready;
	dgpq_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dgpq_rsp_if import dgpq_pkg::*; ();
	logic      valid;
	logic      ready;
	dgpq_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dgpq_cfg_if import dgpq_pkg::*; ();
	logic      valid;
	logic      ready;
	dgpq_cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/dgpq_ram.sv]
// Generic single-port RAM with registered read
`default_nettype none
module dgpq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

[design/dgpq_div.sv]
// Restoring divider, one quotient bit per cycle, saturating above QB bits
`default_nettype none
module dgpq_div import dgpq_pkg::*; #(
	parameter int QB = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [QB-1:0]     quo
);
	localparam int SW  = DIV_DW + QB + 1;
	localparam int CNW = (QB > 1) ? $clog2(QB) : 1;

	logic              run_q;
	logic              done_q;
	logic [CNW-1:0]    cnt_q;
	logic [DIV_NW-1:0] rem_q;
	logic [SW-1:0]     dsh_q;
	logic [QB-1:0]     quo_q;
	logic              sat_w;
	logic              ge_w;

	assign sat_w = SW'(num) >= (SW'(den) << QB);
	assign ge_w  = SW'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !sat_w;
				done_q <= sat_w;
				cnt_q  <= CNW'(QB - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= SW'(den) << (QB - 1);
			quo_q <= sat_w ? '1 : '0;
		end else if (run_q) begin
			if (ge_w) begin
				rem_q <= rem_q - dsh_q[DIV_NW-1:0];
			end
			quo_q <= (quo_q << 1) | QB'(ge_w);
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

[design/distance_grid_point_query.sv]
// Top level: nearest-sample lookup in a signed-distance grid
// Query: each axis in turn goes through the range check, the shared divider (one quotient
// bit a cycle, QB = clog2 of the largest grid axis) and the shared multiplier. A sample
// write is stored when it is accepted.
// One item at a time; a result waits in the output register while the next item is
// accepted. Reset clears control state and loads the register reset values; grid contents
// are undefined until written.
`default_nettype none
module distance_grid_point_query import dgpq_pkg::*; #(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	dgpq_req_if.sink    req,
	dgpq_rsp_if.source  rsp,
	dgpq_cfg_if.sink    cfg
);
	localparam int GMAX  = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
	                                         : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
	localparam int QB    = $clog2(GMAX);
	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int MAW   = $clog2(CELLS);
	localparam logic [QB-1:0] NM1_X = QB'(GRID_X - 1);
	localparam logic [QB-1:0] NM1_Y = QB'(GRID_Y - 1);
	localparam logic [QB-1:0] NM1_Z = QB'(GRID_Z - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_TOP, S_CHK, S_DIV, S_QMUL, S_DIFF, S_RD, S_DOT, S_FIN
	} state_t;

	state_t                   state_q;
	logic [1:0]               ax_q;
	logic [1:0]               dot_q;
	logic                     oor_q;
	dgpq_req_t                req_q;
	logic signed [31:0]       org_q [3];
	logic [30:0]              sp_q [3];
	logic [QB-1:0]            idx_q [3];
	logic signed [MUL_W-1:0]  diff_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     rsp_valid_q;
	dgpq_rsp_t                rsp_data_q;

	logic                       accept_w;
	logic                       wr_en_w;
	logic signed [31:0]         sel_pos;
	logic signed [31:0]         sel_org;
	logic [30:0]                sel_sp;
	logic [QB-1:0]              sel_nm1;
	logic signed [TOP_W-1:0]    pos_w;
	logic signed [TOP_W-1:0]    top_w;
	logic signed [TOP_W-1:0]    diff_w;
	logic                       oor_w;
	logic signed [32:0]         off_w;
	logic [DIV_NW-1:0]          num_w;
	logic [DIV_DW-1:0]          den_w;
	logic                       div_start;
	logic                       div_done;
	logic [QB-1:0]              div_quo;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [2*MUL_W-1:0]  mul_full;
	logic [MAW-1:0]             wr_addr;
	logic [MAW-1:0]             rd_addr;
	logic [ENTRY_W-1:0]         rd_data;
	logic signed [15:0]         rd_dir [3];
	logic signed [31:0]         rd_dist;
	logic signed [ACC_W-1:0]    accr_w;
	logic signed [ACC_W-1:0]    rnd_w;
	logic signed [CORR_W-1:0]   corr_w;
	logic [CORR_W-1:0]          mag_w;
	logic                       inside_w;
	logic [30:0]                mag_sat;

	assign accept_w = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				sp_q[i]  <= SPACING_RST;
			end
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.addr)
				CFG_ORIGIN_X:  org_q[0] <= cfg.data.wdata;
				CFG_ORIGIN_Y:  org_q[1] <= cfg.data.wdata;
				CFG_ORIGIN_Z:  org_q[2] <= cfg.data.wdata;
				CFG_SPACING_X: sp_q[0]  <= cfg.data.wdata[30:0];
				CFG_SPACING_Y: sp_q[1]  <= cfg.data.wdata[30:0];
				CFG_SPACING_Z: sp_q[2]  <= cfg.data.wdata[30:0];
				default: ;
			endcase
		end
	end

	// per-axis operand selection
	always_comb begin
		unique case (ax_q)
			2'd0: begin
				sel_pos = req_q.pos_x;
				sel_nm1 = NM1_X;
			end
			2'd1: begin
				sel_pos = req_q.pos_y;
				sel_nm1 = NM1_Y;
			end
			default: begin
				sel_pos = req_q.pos_z;
				sel_nm1 = NM1_Z;
			end
		endcase
		sel_org = org_q[ax_q];
		sel_sp  = (sp_q[ax_q] == '0) ? 31'd1 : sp_q[ax_q];
	end

	assign pos_w  = TOP_W'(sel_pos);
	assign top_w  = TOP_W'(sel_org) + prod_q[TOP_W-1:0];
	assign oor_w  = (sel_pos < sel_org) || (pos_w > top_w);
	assign off_w  = 33'(sel_pos) - 33'(sel_org);
	assign num_w  = {off_w, 1'b0} + DIV_NW'(sel_sp);
	assign den_w  = {sel_sp, 1'b0};
	assign diff_w = pos_w - TOP_W'(sel_org) - prod_q[TOP_W-1:0];
	assign div_start = (state_q == S_CHK) && !oor_w;

	dgpq_div #(.QB(QB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_w),
		.den    (den_w),
		.done   (div_done),
		.quo    (div_quo)
	);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_TOP: begin
				mul_a = MUL_W'(sel_nm1);
				mul_b = MUL_W'(sel_sp);
			end
			S_QMUL: begin
				mul_a = MUL_W'(idx_q[ax_q]);
				mul_b = MUL_W'(sel_sp);
			end
			S_DOT: begin
				if (dot_q != 2'd3) begin
					mul_a = MUL_W'(rd_dir[dot_q]);
					mul_b = diff_q[dot_q];
				end
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// grid memory: direction x, y, z then distance
	assign wr_en_w = accept_w && (req.data.opcode == OP_WRITE)
		&& (int'(req.data.cell_x) < GRID_X) && (int'(req.data.cell_y) < GRID_Y)
		&& (int'(req.data.cell_z) < GRID_Z);
	assign wr_addr = MAW'(req.data.cell_x) + MAW'(GRID_X)
		* (MAW'(req.data.cell_y) + MAW'(GRID_Y) * MAW'(req.data.cell_z));
	assign rd_addr = MAW'(idx_q[0]) + MAW'(GRID_X)
		* (MAW'(idx_q[1]) + MAW'(GRID_Y) * MAW'(idx_q[2]));

	dgpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_grid (
		.clk   (clk),
		.we    (wr_en_w),
		.re    (state_q == S_RD),
		.addr  ((state_q == S_RD) ? rd_addr : wr_addr),
		.wdata ({req.data.entry_dir_x, req.data.entry_dir_y, req.data.entry_dir_z,
		         req.data.entry_dist}),
		.rdata (rd_data)
	);

	assign rd_dir[0] = rd_data[79:64];
	assign rd_dir[1] = rd_data[63:48];
	assign rd_dir[2] = rd_data[47:32];
	assign rd_dist   = rd_data[31:0];

	// rounding, correction and magnitude
	assign accr_w   = acc_q + ACC_W'(RND_BIAS);
	assign rnd_w    = accr_w >>> RND_SHIFT;
	assign corr_w   = CORR_W'(rd_dist) - rnd_w[CORR_W-1:0];
	assign inside_w = corr_w > 0;
	assign mag_w    = inside_w ? corr_w : -corr_w;
	assign mag_sat  = (mag_w > CORR_W'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : mag_w[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			dot_q       <= '0;
			oor_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in S_FIN the output register is handled below
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_w && req.data.opcode == OP_QUERY) begin
						ax_q    <= '0;
						oor_q   <= 1'b0;
						state_q <= S_TOP;
					end
				end
				S_TOP: state_q <= S_CHK;
				S_CHK: begin
					if (oor_w) begin
						oor_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q[ax_q] <= (div_quo > sel_nm1) ? sel_nm1 : div_quo;
						state_q     <= S_QMUL;
					end
				end
				S_QMUL: state_q <= S_DIFF;
				S_DIFF: begin
					diff_q[ax_q] <= diff_w[MUL_W-1:0];
					if (ax_q == 2'd2) begin
						state_q <= S_RD;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_TOP;
					end
				end
				S_RD: begin
					dot_q   <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					acc_q <= (dot_q == 2'd0) ? '0 : acc_q + ACC_W'(prod_q);
					dot_q <= dot_q + 1'b1;
					if (dot_q == 2'd3) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						if (oor_q) begin
							rsp_data_q <= '0;
						end else begin
							rsp_data_q.in_range   <= 1'b1;
							rsp_data_q.inside_res <= inside_w;
							rsp_data_q.dir_x      <= rd_dir[0];
							rsp_data_q.dir_y      <= rd_dir[1];
							rsp_data_q.dir_z      <= rd_dir[2];
							rsp_data_q.distance   <= mag_sat;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_full[PROD_W-1:0];
		if (accept_w) begin
			req_q <= req.data;
		end
	end
endmodule
`default_nettype wire

[design/dgpq_chk.sv]
// Port-level checker for the distance grid point query block, with its bind
`default_nettype none
`include "distance_grid_point_query_defines.svh"
module dgpq_chk import dgpq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      req_opcode,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input dgpq_rsp_t rsp_data
);
	`DGPQ_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_opcode == OP_QUERY, !req_ready)
	`DGPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
	`DGPQ_ASSERT_SAME(a_oor_zero, rsp_valid && !rsp_data.in_range, !rsp_data.inside_res && rsp_data.dir_x == '0 && rsp_data.dir_y == '0 && rsp_data.dir_z == '0 && rsp_data.distance == '0)
	`DGPQ_ASSERT_SAME(a_inside_mag, rsp_valid && rsp_data.inside_res, rsp_data.in_range && rsp_data.distance != '0)
endmodule

bind distance_grid_point_query dgpq_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_opcode (req.data.opcode),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data)
);
`default_nettype wire

[tb/sv/dgpq_lookup_checker.sv]
// Checker for the distance grid lookup: watches all channels, predicts each result, compares
`default_nettype none
module dgpq_lookup_checker import dgpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dgpq_req_if   req,
	dgpq_rsp_if   rsp,
	dgpq_cfg_if   cfg,
	output int    errors,
	output int    pending,
	output int    n_hits,
	output int    n_misses
);

	localparam int GN = 16;

	longint org_x, org_y, org_z;
	longint sp_x, sp_y, sp_z;
	logic signed [15:0] mem_dx [GN*GN*GN];
	logic signed [15:0] mem_dy [GN*GN*GN];
	logic signed [15:0] mem_dz [GN*GN*GN];
	logic signed [31:0] mem_dist [GN*GN*GN];
	dgpq_rsp_t due_results [$];

	function automatic bit nearest_cell(input longint p, input longint o, input longint sp,
			output longint idx, output longint d);
		longint spe, top, q;
		spe = (sp == 0) ? 1 : sp;
		top = o + (GN - 1) * spe;
		idx = 0;
		d = 0;
		if (p < o || p > top)
			return 1'b0;
		q = (2 * (p - o) + spe) / (2 * spe);
		if (q > GN - 1)
			q = GN - 1;
		idx = q;
		d = p - (o + q * spe);
		return 1'b1;
	endfunction

	function automatic dgpq_rsp_t predict_lookup(input dgpq_req_t it);
		dgpq_rsp_t r;
		longint ix, iy, iz, dx, dy, dz, acc, corr, mag;
		int c;
		r = '0;
		if (!nearest_cell(longint'(it.pos_x), org_x, sp_x, ix, dx) ||
				!nearest_cell(longint'(it.pos_y), org_y, sp_y, iy, dy) ||
				!nearest_cell(longint'(it.pos_z), org_z, sp_z, iz, dz))
			return r;
		c = int'(ix + GN * (iy + GN * iz));
		acc = longint'(mem_dx[c]) * dx + longint'(mem_dy[c]) * dy + longint'(mem_dz[c]) * dz;
		corr = longint'(mem_dist[c]) - ((acc + 8192) >>> 14);
		if (corr > 64'sd2147483647)
			corr = 64'sd2147483647;
		if (corr < -64'sd2147483648)
			corr = -64'sd2147483648;
		mag = (corr > 0) ? corr : -corr;
		if (mag > 64'sd2147483647)
			mag = 64'sd2147483647;
		r.in_range = 1'b1;
		r.inside_res = corr > 0;
		r.dir_x = mem_dx[c];
		r.dir_y = mem_dy[c];
		r.dir_z = mem_dz[c];
		r.distance = mag[30:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dgpq_rsp_t exp_r;
		int c;
		if (!arst_n) begin
			org_x = 0; org_y = 0; org_z = 0;
			sp_x = longint'(SPACING_RST);
			sp_y = longint'(SPACING_RST);
			sp_z = longint'(SPACING_RST);
			due_results.delete();
			errors = 0;
			pending = 0;
			n_hits = 0;
			n_misses = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_r = due_results.pop_front();
					if (rsp.data.in_range !== exp_r.in_range) begin
						$error("in_range exp %0d got %0d", exp_r.in_range, rsp.data.in_range);
						errors++;
					end
					if (rsp.data.inside_res !== exp_r.inside_res) begin
						$error("inside_res exp %0d got %0d", exp_r.inside_res,
							rsp.data.inside_res);
						errors++;
					end
					if (rsp.data.dir_x !== exp_r.dir_x) begin
						$error("dir_x exp %0d got %0d", exp_r.dir_x, rsp.data.dir_x);
						errors++;
					end
					if (rsp.data.dir_y !== exp_r.dir_y) begin
						$error("dir_y exp %0d got %0d", exp_r.dir_y, rsp.data.dir_y);
						errors++;
					end
					if (rsp.data.dir_z !== exp_r.dir_z) begin
						$error("dir_z exp %0d got %0d", exp_r.dir_z, rsp.data.dir_z);
						errors++;
					end
					if (rsp.data.distance !== exp_r.distance) begin
						$error("distance exp %0d got %0d", exp_r.distance, rsp.data.distance);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.data.opcode == OP_WRITE) begin
					c = req.data.cell_x + GN * (req.data.cell_y + GN * req.data.cell_z);
					mem_dx[c] = req.data.entry_dir_x;
					mem_dy[c] = req.data.entry_dir_y;
					mem_dz[c] = req.data.entry_dir_z;
					mem_dist[c] = req.data.entry_dist;
				end else begin
					exp_r = predict_lookup(req.data);
					if (exp_r.in_range)
						n_hits++;
					else
						n_misses++;
					due_results.push_back(exp_r);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.addr)
					CFG_ORIGIN_X: org_x = longint'(signed'(cfg.data.wdata));
					CFG_ORIGIN_Y: org_y = longint'(signed'(cfg.data.wdata));
					CFG_ORIGIN_Z: org_z = longint'(signed'(cfg.data.wdata));
					CFG_SPACING_X: sp_x = longint'(cfg.data.wdata[30:0]);
					CFG_SPACING_Y: sp_y = longint'(cfg.data.wdata[30:0]);
					CFG_SPACING_Z: sp_z = longint'(cfg.data.wdata[30:0]);
					default: ;
				endcase
			end
			pending = due_results.size();
		end
	end

endmodule
`default_nettype wire

[tb/sv/tb_distance_grid_point_query.sv]
// Testbench top for the distance grid lookup: stimulus, stalls, watchdog and verdict
`default_nettype none
module tb_distance_grid_point_query;
	import dgpq_pkg::*;

	localparam int GN = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;
	int errors, pending, n_hits, n_misses;
	int idle_cycles;
	int items_sent;
	bit quiet;
	bit hold_go, hold_done;
	int stall_cnt;
	longint org [3];
	longint spc [3];
	bit written [GN*GN*GN];

	dgpq_req_if req ();
	dgpq_rsp_if rsp ();
	dgpq_cfg_if cfg ();

	distance_grid_point_query u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	dgpq_lookup_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending), .n_hits(n_hits), .n_misses(n_misses)
	);

	always #1 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_cnt <= 0;
			hold_done <= 1'b0;
		end else if (stall_cnt > 0) begin
			rsp.ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (hold_go && !hold_done) begin
			rsp.ready <= 1'b0;
			hold_done <= 1'b1;
			stall_cnt <= 400;
		end else begin
			rsp.ready <= 1'b1;
			stall_cnt <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// cell a query lands on under the current grid, -1 when outside the box
	function automatic int target_cell(input dgpq_req_t it);
		longint p [3];
		longint sp, top, q;
		int idx [3];
		p[0] = longint'(it.pos_x);
		p[1] = longint'(it.pos_y);
		p[2] = longint'(it.pos_z);
		for (int a = 0; a < 3; a++) begin
			sp = (spc[a] == 0) ? 1 : spc[a];
			top = org[a] + (GN - 1) * sp;
			if (p[a] < org[a] || p[a] > top)
				return -1;
			q = (2 * (p[a] - org[a]) + sp) / (2 * sp);
			if (q > GN - 1)
				q = GN - 1;
			idx[a] = int'(q);
		end
		return idx[0] + GN * (idx[1] + GN * idx[2]);
	endfunction

	task automatic send_beat(input dgpq_req_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (items_sent == 300)
			hold_go = 1'b1;
		if (it.opcode == OP_WRITE)
			written[int'(it.cell_x) + GN * (int'(it.cell_y) + GN * int'(it.cell_z))] = 1'b1;
	endtask

	// a query never reads an unwritten cell: such a cell gets a sample first
	task automatic send_item(input dgpq_req_t it);
		int c;
		if (it.opcode == OP_QUERY) begin
			c = target_cell(it);
			if (c >= 0 && !written[c])
				send_beat(sample_write(c));
		end
		send_beat(it);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [31:0] v);
		cfg.valid <= 1'b1;
		cfg.data <= '{addr: a, wdata: v};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (a == CFG_ORIGIN_X) org[0] = longint'(signed'(v));
		if (a == CFG_ORIGIN_Y) org[1] = longint'(signed'(v));
		if (a == CFG_ORIGIN_Z) org[2] = longint'(signed'(v));
		if (a == CFG_SPACING_X) spc[0] = longint'(v[30:0]);
		if (a == CFG_SPACING_Y) spc[1] = longint'(v[30:0]);
		if (a == CFG_SPACING_Z) spc[2] = longint'(v[30:0]);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic [31:0] ox, oy, oz, sx, sy, sz);
		drain();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_SPACING_X, sx);
		write_reg(CFG_SPACING_Y, sy);
		write_reg(CFG_SPACING_Z, sz);
	endtask

	// mode: 0 inside a random cell, 1 low edge, 2 high edge, 3 just below, 4 just above
	function automatic logic [31:0] aim(input int ax, input int mode);
		longint sp, top, p, half;
		sp = (spc[ax] == 0) ? 1 : spc[ax];
		top = org[ax] + (GN - 1) * sp;
		half = sp / 2;
		case (mode)
			1: p = org[ax];
			2: p = top;
			3: p = org[ax] - 1;
			4: p = top + 1;
			default: p = org[ax] + $urandom_range(0, GN - 1) * sp
				+ (longint'($urandom) % (2 * half + 1)) - half;
		endcase
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function automatic dgpq_req_t sample_write(input int c);
		dgpq_req_t it;
		it = '0;
		it.opcode = OP_WRITE;
		it.cell_x = 4'(c % GN);
		it.cell_y = 4'((c / GN) % GN);
		it.cell_z = 4'(c / (GN * GN));
		it.entry_dir_x = 16'($urandom);
		it.entry_dir_y = 16'($urandom);
		it.entry_dir_z = 16'($urandom);
		it.entry_dist = $urandom;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		return it;
	endfunction

	function automatic dgpq_req_t point_query(input int mx, my, mz);
		dgpq_req_t it;
		it = '0;
		it.opcode = OP_QUERY;
		it.pos_x = aim(0, mx);
		it.pos_y = aim(1, my);
		it.pos_z = aim(2, mz);
		it.cell_x = 4'($urandom);
		it.cell_y = 4'($urandom);
		it.cell_z = 4'($urandom);
		it.entry_dir_x = 16'($urandom);
		it.entry_dir_y = 16'($urandom);
		it.entry_dir_z = 16'($urandom);
		it.entry_dist = $urandom;
		return it;
	endfunction

	task automatic random_phase(input int n);
		dgpq_req_t it;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				it = sample_write($urandom_range(0, GN * GN * GN - 1));
			else if (r < 75)
				it = point_query(0, 0, 0);
			else if (r < 85)
				it = point_query($urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(0, 2));
			else if (r < 93)
				it = point_query($urandom_range(0, 4), $urandom_range(0, 4),
					$urandom_range(0, 4));
			else begin
				it = point_query(0, 0, 0);
				it.pos_x = $urandom;
				it.pos_y = $urandom;
				it.pos_z = $urandom;
			end
			send_item(it);
		end
	endtask

	initial begin
		dgpq_req_t it;
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		items_sent = 0;
		idle_cycles = 0;
		hold_go = 1'b0;
		quiet = 1'b1;
		org = '{0, 0, 0};
		spc = '{65536, 65536, 65536};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme samples at the corners, a zero sample in cell 1
		it = sample_write(0);
		it.entry_dir_x = -16'sd32768; it.entry_dir_y = 16'sd32767;
		it.entry_dir_z = -16'sd32768; it.entry_dist = 32'sh80000000;
		send_item(it);
		it = sample_write(GN * GN * GN - 1);
		it.entry_dir_x = 16'sd32767; it.entry_dir_y = -16'sd32768;
		it.entry_dir_z = 16'sd32767; it.entry_dist = 32'sh7FFFFFFF;
		send_item(it);
		it = sample_write(1);
		it.entry_dir_x = '0; it.entry_dir_y = '0; it.entry_dir_z = '0; it.entry_dist = '0;
		send_item(it);

		// most negative distance at a cell point, zero distance, box edges, outside
		send_item(point_query(1, 1, 1));
		send_item(point_query(2, 2, 2));
		it = point_query(1, 1, 1);
		it.pos_x = 32'sd65536;
		send_item(it);
		send_item(point_query(3, 0, 0));
		send_item(point_query(0, 4, 0));
		send_item(point_query(0, 0, 3));
		send_item(point_query(4, 4, 4));
		it = point_query(0, 0, 0);
		it.pos_x = 32'sh7FFFFFFF; it.pos_y = 32'sh80000000; it.pos_z = 32'sh7FFFFFFF;
		send_item(it);
		it.pos_x = 32'sh80000000; it.pos_y = 32'sh7FFFFFFF; it.pos_z = 32'sh80000000;
		send_item(it);
		send_item(point_query(2, 1, 2));

		quiet = 1'b0;
		random_phase(90);

		set_grid(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF);
		send_item(point_query(1, 2, 1));
		send_item(point_query(2, 1, 2));
		random_phase(80);

		set_grid(32'h7FFFFFF0, 32'hFFFFFFF8, 32'd0, 32'd1, 32'd0, 32'd1);
		send_item(point_query(1, 1, 1));
		send_item(point_query(2, 2, 2));
		random_phase(80);

		set_grid(32'hFFF80000, 32'h00031000, 32'hC0000000, 32'd3, 32'h00018000, 32'h05000000);
		quiet = 1'b1;
		random_phase(30);
		quiet = 1'b0;
		random_phase(70);

		set_grid($urandom, $urandom, $urandom, $urandom_range(1, 32'h7FFFFFFF),
			$urandom_range(1, 1 << 20), $urandom_range(1, 1 << 26));
		random_phase(90);

		drain();
		$display("Lookup run: %0d items, %0d in-box queries, %0d outside-box queries,",
			items_sent, n_hits, n_misses);
		$display("five grid settings incl. extreme origins, unit/zero and maximum spacing.");
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
